FILE: hdl/sha_pkg.sv
// ----------------------------------------------------------------------------
// sha_pkg
// shared types, constants and helper functions of the sha-256 hasher
// ----------------------------------------------------------------------------
package sha_pkg;

    // request queued between the front (word packer) and the back (compressor)
    typedef enum logic [1:0] {
        BLK_MID   = 2'd0,   // full block, chain continues
        BLK_LAST  = 2'd1    // final block of the message, emit digest
    } t_blk_kind;

    typedef struct packed {
        logic [511:0] block;
        t_blk_kind    kind;
    } t_blk_req;

    typedef enum logic [1:0] {
        BK_IDLE  = 2'd0,
        BK_ROUND = 2'd1,
        BK_ADD   = 2'd2,
        BK_OUT   = 2'd3
    } t_bk_state;

    typedef enum logic [1:0] {
        FR_TAKE = 2'd0,
        FR_PAD  = 2'd1,
        FR_LEN  = 2'd2
    } t_fr_state;

    localparam logic [255:0] InitH = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    localparam logic [7:0] PadByte = 8'h80;

    function automatic logic [31:0] round_k(input logic [5:0] i);
        logic [31:0] k;
        case (i)
            6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
            6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
            6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
            6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
            6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
            6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
            6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
            6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
            6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
            6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
            6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
            default: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage

FILE: hdl/sha_front.sv
// ----------------------------------------------------------------------------
// sha_front
// packs message words into 512-bit blocks, appends padding and length
// ----------------------------------------------------------------------------
module sha_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_full,
    input  logic [31:0]       i_data_word,
    input  logic [2:0]        i_byte_count,
    input  logic              i_final_word,
    output logic              o_req_valid,
    input  logic              i_req_ready,
    output sha_pkg::t_blk_req o_req
);

    sha_pkg::t_fr_state r_state, n_state;
    logic [511:0] r_blk, n_blk;
    logic [3:0]   r_widx, n_widx;       // next word slot in the block
    logic [63:0]  r_bits, n_bits;
    logic         r_vld, n_vld;
    sha_pkg::t_blk_req r_out, n_out;
    logic         take;
    logic [2:0]   cnt;
    logic [31:0]  mask, padw;

    assign o_full      = (r_state != sha_pkg::FR_TAKE) || r_vld;
    assign take        = i_push && !o_full;
    assign o_req_valid = r_vld;
    assign o_req       = r_out;

    always_comb begin
        cnt = (i_byte_count > 3'd4) ? 3'd4 : i_byte_count;
        unique case (cnt)
            3'd0:    begin mask = 32'h0;        padw = 32'h80000000; end
            3'd1:    begin mask = 32'hff000000; padw = 32'h00800000; end
            3'd2:    begin mask = 32'hffff0000; padw = 32'h00008000; end
            3'd3:    begin mask = 32'hffffff00; padw = 32'h00000080; end
            default: begin mask = 32'hffffffff; padw = 32'h0;        end
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_blk   = r_blk;
        n_widx  = r_widx;
        n_bits  = r_bits;
        n_vld   = r_vld && !i_req_ready;
        n_out   = r_out;
        if (!n_vld) begin
            unique case (r_state)
                sha_pkg::FR_TAKE: begin
                    if (take) begin
                        if (!i_final_word) begin
                            n_blk[511 - 32*r_widx -: 32] = i_data_word;
                            n_bits = r_bits + 64'd32;
                            n_widx = r_widx + 4'd1;
                            if (r_widx == 4'd15) begin
                                n_vld = 1'b1;
                                n_out = '{block: n_blk, kind: sha_pkg::BLK_MID};
                            end
                        end else begin
                            n_blk[511 - 32*r_widx -: 32] = (i_data_word & mask) | padw;
                            n_bits = r_bits + {58'd0, cnt, 3'd0};
                            n_widx = r_widx + 4'd1;
                            if (r_widx == 4'd15) begin
                                n_vld = 1'b1;
                                n_out = '{block: n_blk, kind: sha_pkg::BLK_MID};
                            end
                            // a full last word leaves the 0x80 byte for the next slot
                            n_state = (cnt == 3'd4) ? sha_pkg::FR_PAD : sha_pkg::FR_LEN;
                            if (cnt != 3'd4 && r_widx == 4'd15)
                                n_state = sha_pkg::FR_LEN;
                        end
                    end
                end
                sha_pkg::FR_PAD: begin
                    n_blk[511 - 32*r_widx -: 32] = {sha_pkg::PadByte, 24'd0};
                    n_widx = r_widx + 4'd1;
                    n_state = sha_pkg::FR_LEN;
                    if (r_widx == 4'd15) begin
                        n_vld = 1'b1;
                        n_out = '{block: n_blk, kind: sha_pkg::BLK_MID};
                    end
                end
                default: begin
                    // zero fill, the length goes into slots 14 and 15
                    if (r_widx == 4'd14 || r_widx == 4'd15) begin
                        if (r_widx != 4'd14) begin
                            n_blk[511 - 32*r_widx -: 32] = 32'd0;
                            n_widx = 4'd0;
                            n_vld  = 1'b1;
                            n_out  = '{block: n_blk, kind: sha_pkg::BLK_MID};
                        end else begin
                            n_blk[63:0] = r_bits;
                            n_widx  = 4'd0;
                            n_bits  = 64'd0;
                            n_vld   = 1'b1;
                            n_out   = '{block: n_blk, kind: sha_pkg::BLK_LAST};
                            n_state = sha_pkg::FR_TAKE;
                        end
                    end else begin
                        n_blk[511 - 32*r_widx -: 32] = 32'd0;
                        n_widx = r_widx + 4'd1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sha_pkg::FR_TAKE;
            r_widx  <= 4'd0;
            r_bits  <= 64'd0;
            r_vld   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_widx  <= n_widx;
            r_bits  <= n_bits;
            r_vld   <= n_vld;
        end
        r_blk <= n_blk;
        r_out <= n_out;
    end

endmodule

FILE: hdl/sha_queue.sv
// ----------------------------------------------------------------------------
// sha_queue
// two-entry block request queue between front and back
// ----------------------------------------------------------------------------
module sha_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr_valid,
    output logic              o_wr_ready,
    input  sha_pkg::t_blk_req i_wr,
    output logic              o_rd_valid,
    input  logic              i_rd_ready,
    output sha_pkg::t_blk_req o_rd
);

    sha_pkg::t_blk_req r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       wr, rd;

    assign o_wr_ready = (r_cnt != 2'd2);
    assign o_rd_valid = (r_cnt != 2'd0);
    assign o_rd       = r_mem[r_rp];
    assign wr         = i_wr_valid && o_wr_ready;
    assign rd         = o_rd_valid && i_rd_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (wr) r_wp <= !r_wp;
            if (rd) r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, wr} - {1'b0, rd};
        end
        if (wr) r_mem[r_wp] <= i_wr;
    end

endmodule

FILE: hdl/sha_back.sv
// ----------------------------------------------------------------------------
// sha_back
// one round per cycle compressor with rolling schedule, digest output stage
// ----------------------------------------------------------------------------
module sha_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    output logic              o_req_ready,
    input  sha_pkg::t_blk_req i_req,
    output logic              o_empty,
    input  logic              i_pop,
    output logic [31:0]       o_digest_word,
    output logic [2:0]        o_word_index,
    output logic              o_digest_done
);

    sha_pkg::t_bk_state r_state, n_state;
    logic [255:0] r_h;
    logic [255:0] r_v;
    logic [511:0] r_w;        // w[t] in top word
    logic [5:0]   r_rnd;
    logic         r_last;
    logic [2:0]   r_oidx;

    logic [31:0] a, b, c, d, e, f, g, h, w0, t1, t2, nw, s0, s1;
    logic [31:0] w1, w9, w14;

    always_comb begin
        {a, b, c, d, e, f, g, h} = r_v;
        w0  = r_w[511 -: 32];
        w1  = r_w[479 -: 32];
        w9  = r_w[223 -: 32];
        w14 = r_w[63 -: 32];
        s0 = sha_pkg::rotr(w1, 7) ^ sha_pkg::rotr(w1, 18) ^ (w1 >> 3);
        s1 = sha_pkg::rotr(w14, 17) ^ sha_pkg::rotr(w14, 19) ^ (w14 >> 10);
        nw = w0 + s0 + w9 + s1;
        t1 = h + (sha_pkg::rotr(e, 6) ^ sha_pkg::rotr(e, 11) ^ sha_pkg::rotr(e, 25))
               + ((e & f) ^ (~e & g)) + sha_pkg::round_k(r_rnd) + w0;
        t2 = (sha_pkg::rotr(a, 2) ^ sha_pkg::rotr(a, 13) ^ sha_pkg::rotr(a, 22))
               + ((a & b) ^ (a & c) ^ (b & c));
    end

    assign o_req_ready   = (r_state == sha_pkg::BK_IDLE);
    assign o_empty       = (r_state != sha_pkg::BK_OUT);
    assign o_digest_word = r_h[255 - 32*r_oidx -: 32];
    assign o_word_index  = r_oidx;
    assign o_digest_done = (r_oidx == 3'd7);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sha_pkg::BK_IDLE:  if (i_req_valid) n_state = sha_pkg::BK_ROUND;
            sha_pkg::BK_ROUND: if (r_rnd == 6'd63) n_state = sha_pkg::BK_ADD;
            sha_pkg::BK_ADD:   n_state = r_last ? sha_pkg::BK_OUT : sha_pkg::BK_IDLE;
            default:           if (i_pop && r_oidx == 3'd7) n_state = sha_pkg::BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sha_pkg::BK_IDLE;
            r_h     <= sha_pkg::InitH;
            r_oidx  <= 3'd0;
        end else begin
            r_state <= n_state;
            if (r_state == sha_pkg::BK_ADD) begin
                for (int j = 0; j < 8; j++)
                    r_h[255 - 32*j -: 32] <= r_h[255 - 32*j -: 32] + r_v[255 - 32*j -: 32];
            end
            if (r_state == sha_pkg::BK_OUT && i_pop) begin
                r_oidx <= r_oidx + 3'd1;
                if (r_oidx == 3'd7) r_h <= sha_pkg::InitH;
            end
        end
        if (r_state == sha_pkg::BK_IDLE) begin
            r_v    <= r_h;
            r_w    <= i_req.block;
            r_rnd  <= 6'd0;
            r_last <= (i_req.kind == sha_pkg::BLK_LAST);
        end else if (r_state == sha_pkg::BK_ROUND) begin
            r_v   <= {t1 + t2, a, b, c, d + t1, e, f, g};
            r_w   <= {r_w[479:0], nw};
            r_rnd <= r_rnd + 6'd1;
        end
    end

endmodule

FILE: hdl/sha256_message_hasher.sv
// ----------------------------------------------------------------------------
// sha256_message_hasher
// sha-256 over a word-streamed byte message, digest out as eight words
// ----------------------------------------------------------------------------
// each 16-word block goes through load, 64 rounds and the final add in the
//   compressor, one round per cycle; the round loop sets throughput
// a message end adds one or two blocks plus eight digest requests drained
//   through pop
// reset: synchronous active low, chain value back to the initial hash, queue
//   and length counter cleared
module sha256_message_hasher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [31:0] i_data_word,
    input  logic [2:0]  i_byte_count,
    input  logic        i_final_word,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_digest_done
);

    // front to queue
    logic              f_valid, f_ready;
    sha_pkg::t_blk_req f_req;
    // queue to back
    logic              b_valid, b_ready;
    sha_pkg::t_blk_req b_req;

    // front: packing, padding and length words
    sha_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_data_word  (i_data_word),
        .i_byte_count (i_byte_count),
        .i_final_word (i_final_word),
        .o_req_valid  (f_valid),
        .i_req_ready  (f_ready),
        .o_req        (f_req)
    );

    // block queue decouples packing from compression
    sha_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (f_valid),
        .o_wr_ready (f_ready),
        .i_wr       (f_req),
        .o_rd_valid (b_valid),
        .i_rd_ready (b_ready),
        .o_rd       (b_req)
    );

    // back: compression and digest output
    sha_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (b_valid),
        .o_req_ready   (b_ready),
        .i_req         (b_req),
        .o_empty       (empty),
        .i_pop         (pop),
        .o_digest_word (o_digest_word),
        .o_word_index  (o_word_index),
        .o_digest_done (o_digest_done)
    );

endmodule

FILE: hdl/sha_checker.sv
// ----------------------------------------------------------------------------
// sha_checker
// port-level checks on the digest output sequence
// ----------------------------------------------------------------------------
module sha_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        empty,
    input logic        pop,
    input logic [31:0] o_digest_word,
    input logic [2:0]  o_word_index,
    input logic        o_digest_done
);

    // done flag only on the last digest word
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_digest_done == (o_word_index == 3'd7)))
        else $error("digest_done mismatch");

    // index advances by one after a non-final pop
    a_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && pop && !o_digest_done) |=> (!empty &&
            o_word_index == $past(o_word_index) + 3'd1))
        else $error("word index skipped");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_digest_word) && $stable(o_word_index)))
        else $error("result changed while stalled");

endmodule

bind sha256_message_hasher sha_checker u_sha_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .empty         (empty),
    .pop           (pop),
    .o_digest_word (o_digest_word),
    .o_word_index  (o_word_index),
    .o_digest_done (o_digest_done)
);
